// ===== rtl/core/gap_run_list_editor_defines.svh =====
// assertion macros for the gap run list editor
// used by files that check their own logic; needs signals aclk and aresetn in scope
`ifndef GAP_RUN_LIST_EDITOR_DEFINES_SVH
`define GAP_RUN_LIST_EDITOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define GRE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define GRE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gre_pkg.sv =====
// shared constants for the gap run list editor
// no dependencies
package gre_pkg;

    // default sizes
    localparam int GRE_MAX_RUNS  = 64;
    localparam int GRE_COL_WIDTH = 32;

    // operation codes
    localparam logic [2:0] KIND_CLEAR  = 3'd0;
    localparam logic [2:0] KIND_APPEND = 3'd1;
    localparam logic [2:0] KIND_INSERT = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_DUMP   = 3'd4;

    // error codes
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;
    localparam logic [1:0] ERR_OVF  = 2'd3;

endpackage

// ===== rtl/core/gre_ram.sv =====
// simple dual-port ram with registered, enabled read
// no dependencies
module gre_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/gap_run_list_editor.sv =====
// gap run list editor top level: control sequencer around a two-bank run memory
// depends on gre_pkg, gre_ram and gap_run_list_editor_defines.svh
//
//  channel | direction | transaction
//  s_      | in        | one operation: kind, position, amount
//  m_      | out       | one status result, or one run per stored run on dump
//
// clear, append and unused kinds go straight to the response; insert makes a scan pass
// and a rewrite pass over the n runs, remove and dump one pass each, all paced by the
// single read port of the run memory.
// edits stream from the active bank into the other bank, which becomes active only
// when the edit ends without error. reset clears the run count and bank select.
// a stalled m_ready holds the dump walk; s_ready is high only between operations.
module gap_run_list_editor
    #(
    parameter int MAX_RUNS  = gre_pkg::GRE_MAX_RUNS,
    parameter int COL_WIDTH = gre_pkg::GRE_COL_WIDTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [2:0]                              s_kind,
    input  logic [COL_WIDTH-1:0]                    s_position,
    input  logic [COL_WIDTH-1:0]                    s_amount,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_is_entry,
    output logic [COL_WIDTH-1:0]                    m_run_start,
    output logic [COL_WIDTH-1:0]                    m_run_len,
    output logic [$clog2(MAX_RUNS+1)-1:0]           m_runs_held,
    output logic [COL_WIDTH+$clog2(MAX_RUNS)-1:0]   m_total_gaps,
    output logic [1:0]                              m_error_code,
    output logic                                    m_last
);
    import gre_pkg::*;
    `include "gap_run_list_editor_defines.svh"

    localparam int IW    = $clog2(MAX_RUNS);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = $clog2(MAX_RUNS + 1);
    localparam int TW    = COL_WIDTH + IW;
    localparam int DW    = 2 * COL_WIDTH;
    localparam logic [COL_WIDTH:0] COL_MAX = {1'b0, {COL_WIDTH{1'b1}}};
    localparam logic [CW-1:0]      MAX_CNT = CW'(MAX_RUNS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_EDIT, ST_FIN, ST_DUMP, ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        MD_EXT, MD_GAP, MD_NEW, MD_REM
    } mode_t;

    state_t                 state_reg, state_next;
    mode_t                  mode_reg, mode_next;
    logic [COL_WIDTH-1:0]   pos_reg, pos_next;
    logic [COL_WIDTH-1:0]   amt_reg, amt_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [TW-1:0]          total_reg, total_next;
    logic                   bank_reg, bank_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;
    logic [CW-1:0]          wr_idx_reg, wr_idx_next;
    logic                   p1_reg, p1_next;
    logic                   p1_inj_reg, p1_inj_next;
    logic [CW-1:0]          p1_idx_reg, p1_idx_next;
    logic [CW-1:0]          ins_idx_reg, ins_idx_next;
    logic                   inj_done_reg, inj_done_next;
    logic                   s0z_reg, s0z_next;
    logic                   g1f_reg, g1f_next, g1v_reg, g1v_next;
    logic                   g2f_reg, g2f_next, g2v_reg, g2v_next;
    logic                   if_reg, if_next;
    logic [CW-1:0]          iidx_reg, iidx_next;
    logic                   ovf_reg, ovf_next;
    logic [TW-1:0]          acc_reg, acc_next;
    logic                   pend_v_reg, pend_v_next;
    logic [COL_WIDTH-1:0]   pend_s_reg, pend_s_next;
    logic [COL_WIDTH-1:0]   pend_l_reg, pend_l_next;
    logic [1:0]             err_reg, err_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   m_entry_reg, m_entry_next;
    logic [COL_WIDTH-1:0]   m_start_reg, m_start_next;
    logic [COL_WIDTH-1:0]   m_len_reg, m_len_next;
    logic [CW-1:0]          m_held_reg, m_held_next;
    logic [TW-1:0]          m_total_reg, m_total_next;
    logic [1:0]             m_err_reg, m_err_next;
    logic                   m_last_reg, m_last_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [DW-1:0]          ram_wdata, ram_rdata;

    logic [COL_WIDTH-1:0]   rd_s, rd_l;
    logic [COL_WIDTH:0]     rd_e, pos_x, amt_x, pos_m1, end_x, app_e;
    logic [COL_WIDTH:0]     ins_s, ins_l;
    logic [COL_WIDTH+1:0]   new_e;
    logic                   ovf_now;
    logic                   rm_keep;
    logic [COL_WIDTH-1:0]   rm_s, rm_l;
    logic                   merge_hit;
    logic                   out_free, iss;

    // run memory: two banks of 2**$clog2(MAX_RUNS) entries, {start, length}
    gre_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_runs (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign rd_s    = ram_rdata[DW-1:COL_WIDTH];
    assign rd_l    = ram_rdata[COL_WIDTH-1:0];
    assign rd_e    = {1'b0, rd_s} + {1'b0, rd_l};
    assign pos_x   = {1'b0, pos_reg};
    assign amt_x   = {1'b0, amt_reg};
    assign pos_m1  = pos_x - 1'b1;
    assign end_x   = pos_x + amt_x;
    assign app_e   = {1'b0, s_position} + {1'b0, s_amount};
    assign out_free = !m_valid_reg || m_ready;

    // insert rewrite of one entry, or the injected new run
    always_comb begin
        ins_s = {1'b0, rd_s};
        ins_l = {1'b0, rd_l};
        if (p1_inj_reg) begin
            ins_s = pos_x;
            ins_l = amt_x;
        end else begin
            case (mode_reg)
                MD_EXT: begin
                    if (p1_idx_reg == '0) ins_l = {1'b0, rd_l} + amt_x;
                    else                  ins_s = {1'b0, rd_s} + amt_x;
                end
                MD_GAP: begin
                    if (pos_x >= {1'b0, rd_s}) begin
                        if (pos_x <= rd_e) ins_l = {1'b0, rd_l} + amt_x;
                    end else begin
                        ins_s = {1'b0, rd_s} + amt_x;
                    end
                end
                MD_NEW: begin
                    if (p1_idx_reg >= ins_idx_reg) ins_s = {1'b0, rd_s} + amt_x;
                end
                default: begin
                end
            endcase
        end
        new_e   = {1'b0, ins_s} + {1'b0, ins_l};
        ovf_now = new_e > {1'b0, COL_MAX};
    end

    // remove rewrite of one entry
    always_comb begin
        rm_keep = 1'b1;
        rm_s    = rd_s;
        rm_l    = rd_l;
        if (rd_e < pos_x) begin
            rm_keep = 1'b1;
        end else if (rd_e <= end_x) begin
            if ({1'b0, rd_s} < pos_x) rm_l = pos_reg - rd_s;
            else                      rm_keep = 1'b0;
        end else if ({1'b0, rd_s} < pos_x) begin
            rm_l = rd_l - amt_reg;
        end else if ({1'b0, rd_s} < end_x) begin
            rm_s = pos_reg;
            rm_l = COL_WIDTH'(rd_e - end_x);
        end else begin
            rm_s = rd_s - amt_reg;
        end
        merge_hit = pend_v_reg &&
                    ({1'b0, rm_s} == ({1'b0, pend_s_reg} + {1'b0, pend_l_reg}));
    end

    // sequencer next state
    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        amt_next      = amt_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        bank_next     = bank_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        p1_next       = p1_reg;
        p1_inj_next   = p1_inj_reg;
        p1_idx_next   = p1_idx_reg;
        ins_idx_next  = ins_idx_reg;
        inj_done_next = inj_done_reg;
        s0z_next      = s0z_reg;
        g1f_next      = g1f_reg;
        g1v_next      = g1v_reg;
        g2f_next      = g2f_reg;
        g2v_next      = g2v_reg;
        if_next       = if_reg;
        iidx_next     = iidx_reg;
        ovf_next      = ovf_reg;
        acc_next      = acc_reg;
        pend_v_next   = pend_v_reg;
        pend_s_next   = pend_s_reg;
        pend_l_next   = pend_l_reg;
        err_next      = err_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_entry_next  = m_entry_reg;
        m_start_next  = m_start_reg;
        m_len_next    = m_len_reg;
        m_held_next   = m_held_reg;
        m_total_next  = m_total_reg;
        m_err_next    = m_err_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = {~bank_reg, wr_idx_reg[IW-1:0]};
        ram_wdata     = {ins_s[COL_WIDTH-1:0], ins_l[COL_WIDTH-1:0]};
        ram_re        = 1'b0;
        ram_raddr     = {bank_reg, rd_idx_reg[IW-1:0]};
        iss           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pos_next      = s_position;
                    amt_next      = s_amount;
                    rd_idx_next   = '0;
                    wr_idx_next   = '0;
                    p1_next       = 1'b0;
                    inj_done_next = 1'b0;
                    s0z_next      = 1'b0;
                    g1f_next      = 1'b0;
                    g1v_next      = 1'b0;
                    g2f_next      = 1'b0;
                    g2v_next      = 1'b0;
                    if_next       = 1'b0;
                    ovf_next      = 1'b0;
                    acc_next      = '0;
                    pend_v_next   = 1'b0;
                    err_next      = ERR_OK;
                    state_next    = ST_RESP;
                    if (s_kind == KIND_CLEAR) begin
                        cnt_next   = '0;
                        total_next = '0;
                    end else if (s_kind == KIND_APPEND ||
                                 (s_kind == KIND_INSERT && cnt_reg == '0)) begin
                        // direct write at the end of the active bank
                        if (s_amount == '0) begin
                            err_next = ERR_ZERO;
                        end else if (cnt_reg == MAX_CNT) begin
                            err_next = ERR_FULL;
                        end else if (app_e > COL_MAX) begin
                            err_next = ERR_OVF;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = {bank_reg, cnt_reg[IW-1:0]};
                            ram_wdata  = {s_position, s_amount};
                            cnt_next   = cnt_reg + 1'b1;
                            total_next = total_reg + TW'(s_amount);
                        end
                    end else if (s_kind == KIND_INSERT) begin
                        if (s_amount == '0) err_next = ERR_ZERO;
                        else                state_next = ST_SCAN;
                    end else if (s_kind == KIND_REMOVE) begin
                        if (s_amount == '0) begin
                            err_next = ERR_ZERO;
                        end else if (cnt_reg != '0) begin
                            mode_next  = MD_REM;
                            state_next = ST_EDIT;
                        end
                    end else if (s_kind == KIND_DUMP) begin
                        if (cnt_reg != '0) state_next = ST_DUMP;
                    end
                end
            end

            // locate gap hits and the insertion point
            ST_SCAN: begin
                if (rd_idx_reg < cnt_reg) begin
                    ram_re      = 1'b1;
                    p1_next     = 1'b1;
                    p1_idx_next = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end else begin
                    p1_next = 1'b0;
                end
                if (p1_reg) begin
                    if (p1_idx_reg == '0) s0z_next = (rd_s == '0);
                    if (!g1f_reg && rd_e > pos_x) begin
                        g1f_next = 1'b1;
                        g1v_next = ({1'b0, rd_s} <= pos_x);
                    end
                    if (!g2f_reg && rd_e > pos_m1) begin
                        g2f_next = 1'b1;
                        g2v_next = ({1'b0, rd_s} <= pos_m1);
                    end
                    if (!if_reg && pos_x <= rd_e) begin
                        if_next   = 1'b1;
                        iidx_next = p1_idx_reg;
                    end
                end
                if (rd_idx_reg == cnt_reg && !p1_reg) state_next = ST_DECIDE;
            end

            ST_DECIDE: begin
                rd_idx_next = '0;
                if (pos_reg == '0) begin
                    mode_next    = s0z_reg ? MD_EXT : MD_NEW;
                    ins_idx_next = '0;
                end else if (g1v_reg || g2v_reg) begin
                    mode_next = MD_GAP;
                end else begin
                    mode_next    = MD_NEW;
                    ins_idx_next = if_reg ? iidx_reg : cnt_reg;
                end
                if (pos_reg == '0 && s0z_reg) begin
                    state_next = ST_EDIT;
                end else if (pos_reg != '0 && (g1v_reg || g2v_reg)) begin
                    state_next = ST_EDIT;
                end else if (cnt_reg == MAX_CNT) begin
                    err_next   = ERR_FULL;
                    state_next = ST_RESP;
                end else begin
                    state_next = ST_EDIT;
                end
            end

            // stream active bank into the other bank
            ST_EDIT: begin
                p1_next = 1'b0;
                if (mode_reg == MD_NEW && !inj_done_reg && rd_idx_reg == ins_idx_reg) begin
                    iss           = 1'b1;
                    p1_next       = 1'b1;
                    p1_inj_next   = 1'b1;
                    inj_done_next = 1'b1;
                end else if (rd_idx_reg < cnt_reg) begin
                    iss         = 1'b1;
                    ram_re      = 1'b1;
                    p1_next     = 1'b1;
                    p1_inj_next = 1'b0;
                    p1_idx_next = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (p1_reg) begin
                    if (mode_reg == MD_REM) begin
                        if (rm_keep) begin
                            acc_next = acc_reg + TW'(rm_l);
                            if (merge_hit) begin
                                pend_l_next = pend_l_reg + rm_l;
                            end else begin
                                if (pend_v_reg) begin
                                    ram_we      = 1'b1;
                                    ram_wdata   = {pend_s_reg, pend_l_reg};
                                    wr_idx_next = wr_idx_reg + 1'b1;
                                end
                                pend_v_next = 1'b1;
                                pend_s_next = rm_s;
                                pend_l_next = rm_l;
                            end
                        end
                    end else begin
                        ram_we      = 1'b1;
                        wr_idx_next = wr_idx_reg + 1'b1;
                        acc_next    = acc_reg + TW'(ins_l[COL_WIDTH-1:0]);
                        if (ovf_now) ovf_next = 1'b1;
                    end
                end
                if (!iss && !p1_reg) state_next = ST_FIN;
            end

            // flush the merge holder on remove and switch banks unless the edit overflowed
            ST_FIN: begin
                state_next = ST_RESP;
                if (ovf_reg) begin
                    err_next = ERR_OVF;
                end else begin
                    bank_next  = ~bank_reg;
                    total_next = acc_reg;
                    cnt_next   = wr_idx_reg;
                    if (mode_reg == MD_REM && pend_v_reg) begin
                        ram_we    = 1'b1;
                        ram_wdata = {pend_s_reg, pend_l_reg};
                        cnt_next  = wr_idx_reg + 1'b1;
                    end
                end
            end

            // walk the list into the output register
            ST_DUMP: begin
                if (p1_reg && out_free) begin
                    m_valid_next = 1'b1;
                    m_entry_next = 1'b1;
                    m_start_next = rd_s;
                    m_len_next   = rd_l;
                    m_held_next  = cnt_reg;
                    m_total_next = total_reg;
                    m_err_next   = ERR_OK;
                    m_last_next  = (p1_idx_reg + 1'b1 == cnt_reg);
                    p1_next      = 1'b0;
                    if (p1_idx_reg + 1'b1 == cnt_reg) state_next = ST_IDLE;
                end
                if (rd_idx_reg < cnt_reg && (!p1_reg || out_free)) begin
                    ram_re      = 1'b1;
                    p1_next     = 1'b1;
                    p1_idx_next = rd_idx_reg;
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end

            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_entry_next = 1'b0;
                    m_start_next = '0;
                    m_len_next   = '0;
                    m_held_next  = cnt_reg;
                    m_total_next = total_reg;
                    m_err_next   = err_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            total_reg   <= '0;
            bank_reg    <= 1'b0;
            p1_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            bank_reg    <= bank_next;
            p1_reg      <= p1_next;
            m_valid_reg <= m_valid_next;
        end
        mode_reg     <= mode_next;
        pos_reg      <= pos_next;
        amt_reg      <= amt_next;
        rd_idx_reg   <= rd_idx_next;
        wr_idx_reg   <= wr_idx_next;
        p1_inj_reg   <= p1_inj_next;
        p1_idx_reg   <= p1_idx_next;
        ins_idx_reg  <= ins_idx_next;
        inj_done_reg <= inj_done_next;
        s0z_reg      <= s0z_next;
        g1f_reg      <= g1f_next;
        g1v_reg      <= g1v_next;
        g2f_reg      <= g2f_next;
        g2v_reg      <= g2v_next;
        if_reg       <= if_next;
        iidx_reg     <= iidx_next;
        ovf_reg      <= ovf_next;
        acc_reg      <= acc_next;
        pend_v_reg   <= pend_v_next;
        pend_s_reg   <= pend_s_next;
        pend_l_reg   <= pend_l_next;
        err_reg      <= err_next;
        m_entry_reg  <= m_entry_next;
        m_start_reg  <= m_start_next;
        m_len_reg    <= m_len_next;
        m_held_reg   <= m_held_next;
        m_total_reg  <= m_total_next;
        m_err_reg    <= m_err_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_is_entry   = m_entry_reg;
    assign m_run_start  = m_start_reg;
    assign m_run_len    = m_len_reg;
    assign m_runs_held  = m_held_reg;
    assign m_total_gaps = m_total_reg;
    assign m_error_code = m_err_reg;
    assign m_last       = m_last_reg;

    // checks
    `GRE_ASSERT_IMP(a_idle_no_stage, s_ready, !p1_reg, "stage busy while idle")
    `GRE_ASSERT_IMP(a_edit_other_bank, ram_we && state_reg != ST_IDLE, ram_waddr[AW-1] != bank_reg, "edit wrote active bank")
    `GRE_ASSERT_NXT(a_ovf_keeps_bank, state_reg == ST_FIN && ovf_reg, $stable(bank_reg), "bank switched on error")
    `GRE_ASSERT_IMP(a_count_bound, m_valid, m_runs_held <= MAX_CNT, "run count above table size")

endmodule
